>>> hdl/ldg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldg_pkg
// Shared constants, codes and controller/datapath interface types of the
// load-based DVFS governor.
// ----------------------------------------------------------------------------
package ldg_pkg;

    localparam int FREQ_WIDTH_DEF = 22;
    localparam int TIME_W         = 32;
    localparam int LOAD_W         = 7;
    localparam int MULT_W         = 4;
    localparam int RES_W          = 24;
    localparam int ACT_W          = 3;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;
    localparam int LOAD_STEPS     = 7;

    localparam int SHORT_MIN_US   = 1000;
    localparam int PCT            = 100;
    localparam int MSL_RESET      = 85;
    localparam int MIN_RES_RESET  = 30000;
    localparam int PMAX_RESET     = 4194303;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE  = 3'd0,
        ACT_RAISE = 3'd1,
        ACT_LOWER = 3'd2,
        ACT_HELD  = 3'd3,
        ACT_SHORT = 3'd4
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_SPEED_LOAD = 3'd0,
        CFG_BOOST_MULT     = 3'd1,
        CFG_BOOST_CAP      = 3'd2,
        CFG_IOWAIT_BUSY    = 3'd3,
        CFG_SUSTAIN_PCT    = 3'd4,
        CFG_MIN_RESIDENCY  = 3'd5,
        CFG_POLICY_MAX     = 3'd6,
        CFG_POLICY_MIN     = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        DIV_SHORT = 2'd0,
        DIV_LONG  = 2'd1,
        DIV_FREQ  = 2'd2
    } div_sel_t;

    typedef enum logic [3:0] {
        S_IDLE   = 4'd0,
        S_CHECK  = 4'd1,
        S_DIV_S  = 4'd2,
        S_DIV_L  = 4'd3,
        S_FREQ   = 4'd4,
        S_BOOST  = 4'd5,
        S_DIV_F  = 4'd6,
        S_CLAMP  = 4'd7,
        S_DECIDE = 4'd8,
        S_OUT    = 4'd9
    } state_t;

    typedef struct packed {
        logic     capture;
        logic     restart_load;
        logic     skip;
        logic     div_start;
        div_sel_t div_sel;
        logic     save_short;
        logic     save_long;
        logic     boost_mul;
        logic     boost_pick;
        logic     save_quot;
        logic     clamp;
        logic     decide;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic restart;
        logic too_short;
        logic boost;
        logic div_busy;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

>>> hdl/load_based_dvfs_governor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// load_based_dvfs_governor
// Load-based DVFS decision block: turns a sample of window timings into a
// raise / lower / hold decision and a stored target frequency.
// ----------------------------------------------------------------------------
// A normal sample runs through the one shared restoring divider, which
// computes the short load and the long load with 7 quotient bits each and
// then the scaled frequency with FREQ_WIDTH + 7 bits, one bit per cycle. A
// boost decision skips the third division; a restart or a too-short sample
// skips all three. One sample is worked on at a time; the result sits in an
// output register, so the next sample is taken while that transaction waits.
// Configuration writes are always ready and must only be issued while the
// block is idle.
// ----------------------------------------------------------------------------
module load_based_dvfs_governor #(
    parameter int FREQ_WIDTH = ldg_pkg::FREQ_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // slave side
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // cur_freq, short_elapsed, short_idle, short_iowait,
    // long_elapsed, long_idle, long_iowait
    input  wire logic [((FREQ_WIDTH+6*ldg_pkg::TIME_W+7)/8)*8-1:0] s_tdata,
    // restart
    input  wire logic [0:0]                        s_tuser,
    // master side
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // target, short_load, long_load
    output logic [((FREQ_WIDTH+2*ldg_pkg::LOAD_W+7)/8)*8-1:0] m_tdata,
    // action
    output logic [ldg_pkg::ACT_W-1:0]              m_tuser,
    // configuration write
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ldg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ldg_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int TW    = ldg_pkg::TIME_W;
    localparam int LW    = ldg_pkg::LOAD_W;
    localparam int OUT_W = ((FREQ_WIDTH + 2*LW + 7) / 8) * 8;

    ldg_pkg::cmd_t    cmd;
    ldg_pkg::status_t st;

    logic [FREQ_WIDTH-1:0] res_target;
    logic [LW-1:0]         res_sl, res_ll;

    assign cfg_ready = 1'b1;

    ldg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    ldg_dp #(
        .FREQ_WIDTH (FREQ_WIDTH)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .st               (st),
        .in_restart       (s_tuser[0]),
        .in_cur_freq      (s_tdata[FREQ_WIDTH-1:0]),
        .in_short_elapsed (s_tdata[FREQ_WIDTH        +: TW]),
        .in_short_idle    (s_tdata[FREQ_WIDTH + TW   +: TW]),
        .in_short_iowait  (s_tdata[FREQ_WIDTH + 2*TW +: TW]),
        .in_long_elapsed  (s_tdata[FREQ_WIDTH + 3*TW +: TW]),
        .in_long_idle     (s_tdata[FREQ_WIDTH + 4*TW +: TW]),
        .in_long_iowait   (s_tdata[FREQ_WIDTH + 5*TW +: TW]),
        .cfg_we           (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_tready         (m_tready),
        .m_tvalid         (m_tvalid),
        .m_action         (m_tuser),
        .m_target_khz     (res_target),
        .m_short_load     (res_sl),
        .m_long_load      (res_ll)
    );

    assign m_tdata = OUT_W'({res_ll, res_sl, res_target});

endmodule
`default_nettype wire

>>> hdl/ldg_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldg_div
// Restoring divider, one quotient bit per cycle. The divisor arrives already
// shifted to the top quotient bit; the dividend must be below twice that.
// ----------------------------------------------------------------------------
module ldg_div #(
    parameter int DIVW = 39,
    parameter int QW   = 29
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [DIVW-1:0]            dividend,
    input  wire logic [DIVW-1:0]            divisor,
    input  wire logic [$clog2(QW+1)-1:0]    steps,
    output logic                            busy,
    output logic [QW-1:0]                   quotient
);

    localparam int CNTW = $clog2(QW + 1);

    logic [DIVW-1:0] rem_reg, rem_next;
    logic [DIVW-1:0] dsh_reg, dsh_next;
    logic [QW-1:0]   q_reg, q_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            rem_ge;

    assign rem_ge   = (rem_reg >= dsh_reg);
    assign busy     = (cnt_reg != '0);
    assign quotient = q_reg;

    always_comb begin
        rem_next = rem_reg;
        dsh_next = dsh_reg;
        q_next   = q_reg;
        cnt_next = cnt_reg;
        if (start) begin
            rem_next = dividend;
            dsh_next = divisor;
            q_next   = '0;
            cnt_next = steps;
        end else if (busy) begin
            rem_next = rem_ge ? (rem_reg - dsh_reg) : rem_reg;
            dsh_next = dsh_reg >> 1;
            q_next   = {q_reg[QW-2:0], rem_ge};
            cnt_next = cnt_reg - CNTW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

endmodule
`default_nettype wire

>>> hdl/ldg_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldg_dp
// Governor datapath: sample capture, configuration registers, load and
// frequency arithmetic around the shared divider, stored target and the
// result register.
// ----------------------------------------------------------------------------
module ldg_dp #(
    parameter int FREQ_WIDTH = ldg_pkg::FREQ_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire ldg_pkg::cmd_t                     cmd,
    output ldg_pkg::status_t                       st,
    input  wire logic                              in_restart,
    input  wire logic [FREQ_WIDTH-1:0]             in_cur_freq,
    input  wire logic [ldg_pkg::TIME_W-1:0]        in_short_elapsed,
    input  wire logic [ldg_pkg::TIME_W-1:0]        in_short_idle,
    input  wire logic [ldg_pkg::TIME_W-1:0]        in_short_iowait,
    input  wire logic [ldg_pkg::TIME_W-1:0]        in_long_elapsed,
    input  wire logic [ldg_pkg::TIME_W-1:0]        in_long_idle,
    input  wire logic [ldg_pkg::TIME_W-1:0]        in_long_iowait,
    input  wire logic                              cfg_we,
    input  wire logic [ldg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ldg_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              m_tready,
    output logic                                   m_tvalid,
    output logic [ldg_pkg::ACT_W-1:0]              m_action,
    output logic [FREQ_WIDTH-1:0]                  m_target_khz,
    output logic [ldg_pkg::LOAD_W-1:0]             m_short_load,
    output logic [ldg_pkg::LOAD_W-1:0]             m_long_load
);

    localparam int TW     = ldg_pkg::TIME_W;
    localparam int LW     = ldg_pkg::LOAD_W;
    localparam int QW     = FREQ_WIDTH + LW;
    localparam int BW     = FREQ_WIDTH + ldg_pkg::MULT_W;
    localparam int LDIV_W = TW + LW;
    localparam int FDIV_W = QW + LW - 1;
    localparam int DIVW   = (FDIV_W > LDIV_W) ? FDIV_W : LDIV_W;
    localparam int CNTW   = $clog2(QW + 1);

    // captured sample
    logic                  restart_reg;
    logic [FREQ_WIDTH-1:0] cur_reg;
    logic [TW-1:0]         s_el_reg, s_id_reg, s_io_reg;
    logic [TW-1:0]         l_el_reg, l_id_reg, l_io_reg;

    // configuration
    logic [LW-1:0]                  msl_reg;
    logic [ldg_pkg::MULT_W-1:0]     bmul_reg;
    logic [FREQ_WIDTH-1:0]          bcap_reg;
    logic                           iow_reg;
    logic [LW-1:0]                  sus_reg;
    logic [ldg_pkg::RES_W-1:0]      minres_reg;
    logic [FREQ_WIDTH-1:0]          pmax_reg;
    logic [FREQ_WIDTH-1:0]          pmin_reg;

    // working and result state
    logic [LW-1:0]           sl_reg, ll_reg;
    logic [BW-1:0]           bprod_reg;
    logic [QW-1:0]           cand_reg, cand_next;
    logic [FREQ_WIDTH-1:0]   nf_reg, nf_next;
    logic [FREQ_WIDTH-1:0]   target_reg, target_next;
    ldg_pkg::action_t        action_reg, action_next;
    logic                    m_tvalid_reg;
    logic [ldg_pkg::ACT_W-1:0] m_action_reg;
    logic [FREQ_WIDTH-1:0]   m_target_reg;
    logic [LW-1:0]           m_sl_reg, m_ll_reg;

    // divider hookup
    logic [DIVW-1:0]  div_dividend, div_divisor;
    logic [CNTW-1:0]  div_steps;
    logic             div_busy;
    logic [QW-1:0]    div_q;

    logic [TW-1:0]    w_el, w_id, w_io, w_idle_adj, w_busy;
    logic [LDIV_W-1:0] w_numer;
    logic             s_zero, l_zero;
    logic [LW-1:0]    load_max;
    logic [FREQ_WIDTH-1:0] f_base;
    logic [LW-1:0]    f_den;
    logic [QW-1:0]    f_prod;
    logic [QW-1:0]    cap_sum, cand_hi;

    // ---------------------------------------------------------------- capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            restart_reg <= in_restart;
            cur_reg     <= in_cur_freq;
            s_el_reg    <= in_short_elapsed;
            s_id_reg    <= in_short_idle;
            s_io_reg    <= in_short_iowait;
            l_el_reg    <= in_long_elapsed;
            l_id_reg    <= in_long_idle;
            l_io_reg    <= in_long_iowait;
        end
    end

    // ---------------------------------------------------------- configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            msl_reg    <= LW'(ldg_pkg::MSL_RESET);
            bmul_reg   <= '0;
            bcap_reg   <= '0;
            iow_reg    <= 1'b0;
            sus_reg    <= '0;
            minres_reg <= ldg_pkg::RES_W'(ldg_pkg::MIN_RES_RESET);
            pmax_reg   <= FREQ_WIDTH'(ldg_pkg::PMAX_RESET);
            pmin_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ldg_pkg::CFG_MAX_SPEED_LOAD: msl_reg    <= cfg_data[LW-1:0];
                ldg_pkg::CFG_BOOST_MULT:     bmul_reg   <= cfg_data[ldg_pkg::MULT_W-1:0];
                ldg_pkg::CFG_BOOST_CAP:      bcap_reg   <= cfg_data[FREQ_WIDTH-1:0];
                ldg_pkg::CFG_IOWAIT_BUSY:    iow_reg    <= cfg_data[0];
                ldg_pkg::CFG_SUSTAIN_PCT:    sus_reg    <= cfg_data[LW-1:0];
                ldg_pkg::CFG_MIN_RESIDENCY:  minres_reg <= cfg_data[ldg_pkg::RES_W-1:0];
                ldg_pkg::CFG_POLICY_MAX:     pmax_reg   <= cfg_data[FREQ_WIDTH-1:0];
                ldg_pkg::CFG_POLICY_MIN:     pmin_reg   <= cfg_data[FREQ_WIDTH-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------ window load
    always_comb begin
        if (cmd.div_sel == ldg_pkg::DIV_LONG) begin
            w_el = l_el_reg;
            w_id = l_id_reg;
            w_io = l_io_reg;
        end else begin
            w_el = s_el_reg;
            w_id = s_id_reg;
            w_io = s_io_reg;
        end
        w_idle_adj = (iow_reg && (w_id >= w_io)) ? (w_id - w_io) : w_id;
        w_busy     = w_el - w_idle_adj;
        w_numer    = LDIV_W'(w_busy) * LDIV_W'(ldg_pkg::PCT);
    end

    assign s_zero = (s_el_reg == '0) || (s_id_reg > s_el_reg);
    assign l_zero = (l_el_reg == '0) || (l_id_reg > l_el_reg);

    // ------------------------------------------------------- frequency scaling
    assign load_max = (ll_reg > sl_reg) ? ll_reg : sl_reg;
    assign f_base   = (sus_reg == '0) ? pmax_reg : cur_reg;
    assign f_den    = (sus_reg == '0) ? LW'(ldg_pkg::PCT) : sus_reg;
    assign f_prod   = QW'(f_base) * QW'(load_max);

    always_comb begin
        case (cmd.div_sel)
            ldg_pkg::DIV_FREQ: begin
                div_dividend = DIVW'(f_prod);
                div_divisor  = DIVW'(f_den) << (QW - 1);
                div_steps    = CNTW'(QW);
            end
            default: begin
                div_dividend = DIVW'(w_numer);
                div_divisor  = DIVW'({w_el, {(ldg_pkg::LOAD_STEPS-1){1'b0}}});
                div_steps    = CNTW'(ldg_pkg::LOAD_STEPS);
            end
        endcase
    end

    ldg_div #(
        .DIVW (DIVW),
        .QW   (QW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // ----------------------------------------------------------- boost / clamp
    assign cap_sum = QW'(cur_reg) + QW'(bcap_reg);
    assign cand_hi = (cand_reg > QW'(pmax_reg)) ? QW'(pmax_reg) : cand_reg;

    always_comb begin
        cand_next = cand_reg;
        if (cmd.boost_pick) begin
            if (bmul_reg == '0) begin
                cand_next = QW'(pmax_reg);
            end else if ((bcap_reg != '0) && (QW'(bprod_reg) > cap_sum)) begin
                cand_next = cap_sum;
            end else begin
                cand_next = QW'(bprod_reg);
            end
        end else if (cmd.save_quot) begin
            cand_next = div_q;
        end
        nf_next = nf_reg;
        if (cmd.clamp) begin
            nf_next = (cand_hi < QW'(pmin_reg)) ? pmin_reg : cand_hi[FREQ_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.boost_mul) begin
            bprod_reg <= BW'(cur_reg) * BW'(bmul_reg);
        end
        cand_reg <= cand_next;
        nf_reg   <= nf_next;
        if (cmd.restart_load || cmd.skip) begin
            sl_reg <= '0;
            ll_reg <= '0;
        end else begin
            if (cmd.save_short) begin
                sl_reg <= s_zero ? '0 : div_q[LW-1:0];
            end
            if (cmd.save_long) begin
                ll_reg <= l_zero ? '0 : div_q[LW-1:0];
            end
        end
    end

    // ---------------------------------------------------------------- decision
    always_comb begin
        target_next = target_reg;
        action_next = action_reg;
        if (cmd.restart_load) begin
            target_next = cur_reg;
            action_next = ldg_pkg::ACT_NONE;
        end else if (cmd.skip) begin
            action_next = ldg_pkg::ACT_SHORT;
        end else if (cmd.decide) begin
            if (nf_reg == target_reg) begin
                action_next = ldg_pkg::ACT_NONE;
            end else if (nf_reg < target_reg) begin
                if (l_el_reg < TW'(minres_reg)) begin
                    action_next = ldg_pkg::ACT_HELD;
                end else begin
                    target_next = nf_reg;
                    action_next = ldg_pkg::ACT_LOWER;
                end
            end else begin
                target_next = nf_reg;
                action_next = ldg_pkg::ACT_RAISE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            target_reg <= target_next;
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        action_reg <= action_next;
        if (cmd.out_load) begin
            m_action_reg <= action_reg;
            m_target_reg <= target_reg;
            m_sl_reg     <= sl_reg;
            m_ll_reg     <= ll_reg;
        end
    end

    // ------------------------------------------------------------------ status
    assign st.restart   = restart_reg;
    assign st.too_short = (s_el_reg < TW'(ldg_pkg::SHORT_MIN_US));
    assign st.boost     = (load_max >= msl_reg);
    assign st.div_busy  = div_busy;
    assign st.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid      = m_tvalid_reg;
    assign m_action      = m_action_reg;
    assign m_target_khz  = m_target_reg;
    assign m_short_load  = m_sl_reg;
    assign m_long_load   = m_ll_reg;

endmodule
`default_nettype wire

>>> hdl/ldg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldg_ctrl
// Governor sequencer: accepts a sample, steps the datapath through the two
// load divisions, frequency step, clamp and decision (a restart or too-short
// sample skips them), then hands the result to the output register.
// ----------------------------------------------------------------------------
module ldg_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire ldg_pkg::status_t  st,
    output ldg_pkg::cmd_t          cmd
);

    ldg_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ldg_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ldg_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    state_next = ldg_pkg::S_CHECK;
                end
            end
            ldg_pkg::S_CHECK: begin
                if (st.restart || st.too_short) begin
                    state_next = ldg_pkg::S_OUT;
                end else begin
                    state_next = ldg_pkg::S_DIV_S;
                end
            end
            ldg_pkg::S_DIV_S: begin
                if (!st.div_busy) begin
                    state_next = ldg_pkg::S_DIV_L;
                end
            end
            ldg_pkg::S_DIV_L: begin
                if (!st.div_busy) begin
                    state_next = ldg_pkg::S_FREQ;
                end
            end
            ldg_pkg::S_FREQ: begin
                state_next = st.boost ? ldg_pkg::S_BOOST : ldg_pkg::S_DIV_F;
            end
            ldg_pkg::S_BOOST: begin
                state_next = ldg_pkg::S_CLAMP;
            end
            ldg_pkg::S_DIV_F: begin
                if (!st.div_busy) begin
                    state_next = ldg_pkg::S_CLAMP;
                end
            end
            ldg_pkg::S_CLAMP: begin
                state_next = ldg_pkg::S_DECIDE;
            end
            ldg_pkg::S_DECIDE: begin
                state_next = ldg_pkg::S_OUT;
            end
            ldg_pkg::S_OUT: begin
                if (st.out_free) begin
                    state_next = ldg_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ldg_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ldg_pkg::S_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ldg_pkg::S_CHECK: begin
                if (st.restart) begin
                    cmd.restart_load = 1'b1;
                end else if (st.too_short) begin
                    cmd.skip = 1'b1;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = ldg_pkg::DIV_SHORT;
                end
            end
            ldg_pkg::S_DIV_S: begin
                if (!st.div_busy) begin
                    cmd.save_short = 1'b1;
                    cmd.div_start  = 1'b1;
                    cmd.div_sel    = ldg_pkg::DIV_LONG;
                end
            end
            ldg_pkg::S_DIV_L: begin
                cmd.save_long = !st.div_busy;
                cmd.div_sel   = ldg_pkg::DIV_LONG;
            end
            ldg_pkg::S_FREQ: begin
                if (st.boost) begin
                    cmd.boost_mul = 1'b1;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = ldg_pkg::DIV_FREQ;
                end
            end
            ldg_pkg::S_BOOST: begin
                cmd.boost_pick = 1'b1;
            end
            ldg_pkg::S_DIV_F: begin
                cmd.save_quot = !st.div_busy;
            end
            ldg_pkg::S_CLAMP: begin
                cmd.clamp = 1'b1;
            end
            ldg_pkg::S_DECIDE: begin
                cmd.decide = 1'b1;
            end
            ldg_pkg::S_OUT: begin
                cmd.out_load = st.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !st.div_busy)
        else $error("divider restarted while busy");

    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> st.out_free)
        else $error("result loaded over a pending transaction");

    a_one_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second sample accepted while one is in flight");
`endif

endmodule
`default_nettype wire

>>> tb/ldg_decision_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldg_decision_checker
// Watches the sample, decision and register channels of the governor. It
// keeps its own copy of the registers and of the stored target, predicts
// each decision when a sample transaction is taken, and compares every
// decision transaction with the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module ldg_decision_checker #(
    parameter int FW = ldg_pkg::FREQ_WIDTH_DEF
) (
    input  wire logic                                              aclk,
    input  wire logic                                              aresetn,
    input  wire logic                                              s_tvalid,
    input  wire logic                                              s_tready,
    input  wire logic [((FW+6*ldg_pkg::TIME_W+7)/8)*8-1:0]         s_tdata,
    input  wire logic [0:0]                                        s_tuser,
    input  wire logic                                              m_tvalid,
    input  wire logic                                              m_tready,
    input  wire logic [((FW+2*ldg_pkg::LOAD_W+7)/8)*8-1:0]         m_tdata,
    input  wire logic [ldg_pkg::ACT_W-1:0]                         m_tuser,
    input  wire logic                                              cfg_valid,
    input  wire logic                                              cfg_ready,
    input  wire logic [ldg_pkg::CFG_IDX_W-1:0]                     cfg_index,
    input  wire logic [ldg_pkg::CFG_DATA_W-1:0]                    cfg_data,
    output int                                                     n_bad,
    output int                                                     n_waiting
);
    import ldg_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct {
        action_t           act;
        logic [FW-1:0]     target;
        logic [LOAD_W-1:0] short_pct;
        logic [LOAD_W-1:0] long_pct;
    } decision_t;

    logic [LOAD_W-1:0] boost_load;
    logic [MULT_W-1:0] boost_mult;
    logic [FW-1:0]     boost_cap;
    logic              iowait_busy;
    logic [LOAD_W-1:0] sustain_pct;
    logic [RES_W-1:0]  min_residency;
    logic [FW-1:0]     freq_ceiling;
    logic [FW-1:0]     freq_floor;
    logic [FW-1:0]     held_target;
    decision_t         due_decisions[$];
    int                result_count;

    function automatic logic [LOAD_W-1:0] busy_pct(input logic [TIME_W-1:0] el,
                                                   input logic [TIME_W-1:0] idl,
                                                   input logic [TIME_W-1:0] io);
        logic [63:0] idle_part;
        if (el == 0 || idl > el)
            return '0;
        idle_part = 64'(idl);
        if (iowait_busy && idl >= io)
            idle_part = 64'(idl) - 64'(io);
        return LOAD_W'((64'd100 * (64'(el) - idle_part)) / 64'(el));
    endfunction

    function automatic logic [FW-1:0] scaled_freq(input logic [LOAD_W-1:0] load,
                                                  input logic [FW-1:0] cur);
        logic [63:0] f;
        if (load >= boost_load) begin
            if (boost_mult == 0) begin
                f = 64'(freq_ceiling);
            end else begin
                f = 64'(cur) * 64'(boost_mult);
                if (boost_cap != 0 && f > 64'(cur) + 64'(boost_cap))
                    f = 64'(cur) + 64'(boost_cap);
            end
        end else if (sustain_pct == 0) begin
            f = 64'(freq_ceiling) * 64'(load) / 64'd100;
        end else begin
            f = 64'(cur) * 64'(load) / 64'(sustain_pct);
        end
        if (f > 64'(freq_ceiling))
            f = 64'(freq_ceiling);
        if (f < 64'(freq_floor))
            f = 64'(freq_floor);
        return f[FW-1:0];
    endfunction

    function automatic decision_t predict_decision(input logic rst,
                                                   input logic [FW-1:0] cur,
                                                   input logic [TIME_W-1:0] se,
                                                   input logic [TIME_W-1:0] si,
                                                   input logic [TIME_W-1:0] sio,
                                                   input logic [TIME_W-1:0] le,
                                                   input logic [TIME_W-1:0] li,
                                                   input logic [TIME_W-1:0] lio);
        decision_t         d;
        logic [LOAD_W-1:0] peak;
        logic [FW-1:0]     nf;
        d.act       = ACT_NONE;
        d.target    = held_target;
        d.short_pct = '0;
        d.long_pct  = '0;
        if (rst) begin
            d.target = cur;
        end else if (se < SHORT_MIN_US) begin
            d.act = ACT_SHORT;
        end else begin
            d.short_pct = busy_pct(se, si, sio);
            d.long_pct  = busy_pct(le, li, lio);
            peak = (d.long_pct > d.short_pct) ? d.long_pct : d.short_pct;
            nf = scaled_freq(peak, cur);
            if (nf < held_target) begin
                if (le < min_residency) begin
                    d.act = ACT_HELD;
                end else begin
                    d.act    = ACT_LOWER;
                    d.target = nf;
                end
            end else if (nf > held_target) begin
                d.act    = ACT_RAISE;
                d.target = nf;
            end
        end
        return d;
    endfunction

    always @(posedge aclk) begin : watch
        decision_t want;
        decision_t got;
        if (!aresetn) begin
            boost_load    = LOAD_W'(MSL_RESET);
            boost_mult    = '0;
            boost_cap     = '0;
            iowait_busy   = 1'b0;
            sustain_pct   = '0;
            min_residency = RES_W'(MIN_RES_RESET);
            freq_ceiling  = FW'(PMAX_RESET);
            freq_floor    = '0;
            held_target   = '0;
            result_count  = 0;
            n_bad         = 0;
            due_decisions.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_MAX_SPEED_LOAD: boost_load    = cfg_data[LOAD_W-1:0];
                    CFG_BOOST_MULT:     boost_mult    = cfg_data[MULT_W-1:0];
                    CFG_BOOST_CAP:      boost_cap     = cfg_data[FW-1:0];
                    CFG_IOWAIT_BUSY:    iowait_busy   = cfg_data[0];
                    CFG_SUSTAIN_PCT:    sustain_pct   = cfg_data[LOAD_W-1:0];
                    CFG_MIN_RESIDENCY:  min_residency = cfg_data[RES_W-1:0];
                    CFG_POLICY_MAX:     freq_ceiling  = cfg_data[FW-1:0];
                    CFG_POLICY_MIN:     freq_floor    = cfg_data[FW-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.act       = action_t'(m_tuser);
                got.target    = m_tdata[FW-1:0];
                got.short_pct = m_tdata[FW +: LOAD_W];
                got.long_pct  = m_tdata[FW+LOAD_W +: LOAD_W];
                result_count++;
                if (due_decisions.size() == 0) begin
                    if (n_bad < REPORT_LIMIT)
                        $display({"decision %0d with no sample outstanding:",
                                  " action %0d target %0d"},
                                 result_count, got.act, got.target);
                    n_bad++;
                end else begin
                    want = due_decisions.pop_front();
                    if (got.act !== want.act || got.target !== want.target ||
                        got.short_pct !== want.short_pct || got.long_pct !== want.long_pct) begin
                        if (n_bad < REPORT_LIMIT)
                            $display({"decision %0d: expected action %0d target %0d loads %0d/%0d,",
                                      " got action %0d target %0d loads %0d/%0d"},
                                     result_count, want.act, want.target, want.short_pct,
                                     want.long_pct, got.act, got.target, got.short_pct,
                                     got.long_pct);
                        n_bad++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                want = predict_decision(s_tuser[0], s_tdata[FW-1:0],
                                        s_tdata[FW +: TIME_W],
                                        s_tdata[FW+TIME_W +: TIME_W],
                                        s_tdata[FW+2*TIME_W +: TIME_W],
                                        s_tdata[FW+3*TIME_W +: TIME_W],
                                        s_tdata[FW+4*TIME_W +: TIME_W],
                                        s_tdata[FW+5*TIME_W +: TIME_W]);
                held_target = want.target;
                due_decisions.push_back(want);
            end
        end
        n_waiting = due_decisions.size();
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the governor with directed corner samples and then with phases of
// random samples, each phase under freshly written register settings, with
// random idle cycles on both stream sides outside one calm phase. The checker
// beside the block predicts and compares; this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import ldg_pkg::*;

    localparam int FW            = FREQ_WIDTH_DEF;
    localparam int S_W           = ((FW + 6*TIME_W + 7) / 8) * 8;
    localparam int M_W           = ((FW + 2*LOAD_W + 7) / 8) * 8;
    localparam int FREQ_ALL_ONES = (1 << FW) - 1;
    localparam int RANDOM_ITEMS  = 1150;
    localparam int PHASES        = 10;
    localparam int CALM_PHASE    = 4;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int END_SETTLE    = 60;
    localparam logic [31:0] ONES = 32'hFFFF_FFFF;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    // cur_freq, short_elapsed, short_idle, short_iowait,
    // long_elapsed, long_idle, long_iowait
    logic [S_W-1:0]       s_tdata   = '0;
    // restart
    logic [0:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // target, short_load, long_load
    logic [M_W-1:0]       m_tdata;
    // action
    logic [ACT_W-1:0]     m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int n_bad;
    int n_waiting;
    bit calm         = 1'b0;
    int samples_sent = 0;
    int reg_writes   = 0;
    int cycle_count  = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    load_based_dvfs_governor #(.FREQ_WIDTH(FW)) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ldg_decision_checker #(.FW(FW)) u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .n_bad     (n_bad),
        .n_waiting (n_waiting)
    );

    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 36);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_sample(input logic rst, input logic [FW-1:0] cur,
                               input logic [31:0] se, input logic [31:0] si,
                               input logic [31:0] sio, input logic [31:0] le,
                               input logic [31:0] li, input logic [31:0] lio);
        int gap;
        gap = 0;
        if (!calm) begin
            if ($urandom_range(11) == 0)
                gap = $urandom_range(1, 60);
            else
                while ($urandom_range(99) < 36)
                    gap++;
        end
        @(negedge aclk);
        if (gap > 0) begin
            // idle while the block is ready, not while it is still busy
            s_tvalid <= 1'b0;
            while (!s_tready)
                @(negedge aclk);
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rst;
        s_tdata  <= S_W'({lio, li, le, sio, si, se, cur});
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
    endtask

    // drop valid and hold until every decision has come back
    task automatic wait_quiet();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (n_waiting != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    task automatic write_all(input logic [31:0] msl, input logic [31:0] mult,
                             input logic [31:0] cap, input logic [31:0] iow,
                             input logic [31:0] sus, input logic [31:0] res,
                             input logic [31:0] fmax, input logic [31:0] fmin);
        write_reg(CFG_MAX_SPEED_LOAD, msl);
        write_reg(CFG_BOOST_MULT, mult);
        write_reg(CFG_BOOST_CAP, cap);
        write_reg(CFG_IOWAIT_BUSY, iow);
        write_reg(CFG_SUSTAIN_PCT, sus);
        write_reg(CFG_MIN_RESIDENCY, res);
        write_reg(CFG_POLICY_MAX, fmax);
        write_reg(CFG_POLICY_MIN, fmin);
    endtask

    function automatic logic [31:0] pick_setting(input cfg_idx_t idx);
        int          roll;
        logic [31:0] v;
        roll = $urandom_range(9);
        case (idx)
            CFG_MAX_SPEED_LOAD:
                v = (roll == 0) ? 0 : (roll == 1) ? 127 : (roll == 2) ? 100 :
                    $urandom_range(40, 99);
            CFG_BOOST_MULT:
                v = (roll < 3) ? 0 : (roll == 3) ? 15 : $urandom_range(1, 4);
            CFG_BOOST_CAP:
                v = (roll < 4) ? 0 : (roll == 4) ? FREQ_ALL_ONES : $urandom_range(1, 1500000);
            CFG_IOWAIT_BUSY:
                v = roll % 2;
            CFG_SUSTAIN_PCT:
                v = (roll < 3) ? 0 : (roll == 3) ? 127 : (roll == 4) ? 1 :
                    $urandom_range(40, 100);
            CFG_MIN_RESIDENCY:
                v = (roll == 0) ? 0 : (roll == 1) ? 32'hFF_FFFF : $urandom_range(0, 60000);
            CFG_POLICY_MAX:
                v = (roll == 0) ? 0 : (roll < 3) ? FREQ_ALL_ONES :
                    $urandom_range(500000, FREQ_ALL_ONES);
            CFG_POLICY_MIN:
                v = (roll == 0) ? FREQ_ALL_ONES : (roll < 4) ? 0 : $urandom_range(0, 1000000);
            default:
                v = 0;
        endcase
        return v;
    endfunction

    task automatic random_sample();
        int            kind;
        logic          rst;
        logic [FW-1:0] cur;
        logic [31:0]   se, si, sio, le, li, lio;
        kind = $urandom_range(99);
        rst  = 1'b0;
        cur  = ($urandom_range(1) == 0) ? FW'($urandom_range(0, FREQ_ALL_ONES)) :
                                          FW'($urandom_range(50000, 2500000));
        se  = $urandom();
        si  = $urandom();
        sio = $urandom();
        le  = $urandom();
        li  = $urandom();
        lio = $urandom();
        if (kind < 6) begin
            rst = 1'b1;
        end else if (kind < 11) begin
            se = $urandom_range(0, SHORT_MIN_US - 1);
        end else if (kind >= 22) begin
            se  = $urandom_range(SHORT_MIN_US, 100000);
            si  = ($urandom_range(19) == 0) ? se + $urandom_range(1, 1000) :
                                             $urandom_range(0, se);
            sio = ($urandom_range(4) == 0) ? $urandom_range(0, se) : $urandom_range(0, si);
            le  = ($urandom_range(9) == 0) ? 0 : $urandom_range(0, 120000);
            li  = ($urandom_range(19) == 0) ? le + 1 : $urandom_range(0, le);
            lio = ($urandom_range(4) == 0) ? $urandom_range(0, le + 1) : $urandom_range(0, li);
        end
        send_sample(rst, cur, se, si, sio, le, li, lio);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings, stored target still zero
        send_sample(0, 1500000, 10000, 5000, 0, 0, 0, 0);
        send_sample(1, FW'(FREQ_ALL_ONES), ONES, ONES, ONES, ONES, ONES, ONES);
        send_sample(0, 1000000, 999, 0, 0, ONES, ONES, ONES);
        send_sample(0, 0, 0, ONES, ONES, ONES, ONES, ONES);
        send_sample(0, 1000000, 1000, 0, 0, 0, 0, 0);
        send_sample(0, 1000000, ONES, ONES, 0, 5000, 6000, 0);
        send_sample(0, 1000000, ONES, ONES, 0, 30000, 30000, 0);
        send_sample(0, 1000000, 2000, 1000, 1500, ONES, 0, ONES);

        // no boost reachable, sustain above 100, iowait counted busy
        wait_quiet();
        write_all(127, 15, 1000, 1, 127, 0, 3000000, 100000);
        send_sample(1, 1000000, 0, 0, 0, 0, 0, 0);
        send_sample(0, 1000000, 10000, 0, 0, 0, 0, 0);
        send_sample(0, 1000000, 10000, 2000, 3000, 0, 0, 0);
        send_sample(0, 1000000, 10000, 4000, 3000, 0, 0, 0);
        send_sample(0, FW'(FREQ_ALL_ONES), 10000, 0, 0, 0, 0, 0);
        send_sample(0, 500000, 10000, ONES, 0, 0, 0, 0);

        // always boost, uncapped multiplier, longest residency
        wait_quiet();
        write_all(0, 15, 0, 0, 0, 32'hFF_FFFF, FREQ_ALL_ONES, 0);
        send_sample(1, 200000, 0, 0, 0, 0, 0, 0);
        send_sample(0, 200000, 5000, 5000, 0, 0, 0, 0);
        send_sample(0, FW'(FREQ_ALL_ONES), 5000, 5000, 0, 0, 0, 0);
        send_sample(0, 100000, 5000, 5000, 0, 0, 0, 0);

        // capped boost and scaling against the sustain load
        wait_quiet();
        write_all(50, 3, 500000, 0, 50, 1000, FREQ_ALL_ONES, 0);
        send_sample(1, 1000000, 0, 0, 0, 0, 0, 0);
        send_sample(0, 1000000, 10000, 0, 0, 0, 0, 0);
        send_sample(0, 1000000, 10000, 7500, 0, 1000, 1000, 0);

        // floor above ceiling
        wait_quiet();
        write_reg(CFG_POLICY_MAX, 1000);
        write_reg(CFG_POLICY_MIN, FREQ_ALL_ONES);
        send_sample(0, 1000000, 10000, 0, 0, 0, 0, 0);
        send_sample(0, 1000000, 10000, 9000, 0, 0, 0, 0);

        for (int p = 0; p < PHASES; p++) begin
            wait_quiet();
            calm = (p == CALM_PHASE);
            for (int r = 0; r < 8; r++)
                write_reg(cfg_idx_t'(r), pick_setting(cfg_idx_t'(r)));
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
                random_sample();
        end

        wait_quiet();
        repeat (END_SETTLE) @(posedge aclk);
        $display("run covered %0d samples (corner cases, then %0d random phases)",
                 samples_sent, PHASES);
        $display("and %0d register writes", reg_writes);
        if (n_bad == 0 && n_waiting == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
